// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/twc_pkg.sv -----
// shared types, constants and helpers of the text cell writer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package twc_pkg;

	localparam logic [7:0] MAX_COLUMNS = 8'd128;
	localparam logic [6:0] MAX_ROWS    = 7'd64;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COLUMNS = 2'd0,
		CFG_ROWS    = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MODE_STRING = 3'd0,
		MODE_SINGLE = 3'd1,
		MODE_MOVE   = 3'd2,
		MODE_FORE   = 3'd3,
		MODE_BACK   = 3'd4
	} mode_t;

	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_NEWLINE = 8'h6e;
	localparam logic [7:0] CHAR_SLASH   = 8'h2f;

	localparam logic [7:0]  COLUMNS_RESET = 8'd80;
	localparam logic [6:0]  ROWS_RESET    = 7'd25;
	localparam logic [23:0] FORE_RESET    = 24'hFFFFFF;
	localparam logic [23:0] BACK_RESET    = 24'h000000;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] char_code;
		logic       end_of_string;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_word_t;

	typedef struct packed {
		logic [6:0] cell_x;
		logic [5:0] cell_y;
		logic [7:0] tile_u;
		logic [7:0] tile_v;
		logic [7:0] fore_red;
		logic [7:0] fore_green;
		logic [7:0] fore_blue;
		logic [7:0] back_red;
		logic [7:0] back_green;
		logic [7:0] back_blue;
	} out_word_t;

	// classified word passed from front to back
	typedef struct packed {
		logic [2:0]  mode;
		logic        eos;
		logic [7:0]  tile_u;
		logic [7:0]  tile_v;
		logic        is_percent;
		logic        is_newline;
		logic        is_slash;
		logic        is_hex;
		logic [3:0]  hex_digit;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [23:0] rgb;
	} cls_t;

	// {valid, digit}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/text_cell_writer_color_escapes.sv -----
// top level of the text cell writer with color escapes
// depends on twc_pkg, twc_front, twc_back
//
// usage:
//   input channel: a word is taken on a clock edge with push high and full low.
//   mode 0 words are string characters run through the escape parser
//   (%% prints '%', %n starts the next row, %RRGGBB[/RRGGBB] sets colors);
//   modes 1 to 4 print one character, move the cursor or set a color.
//   result channel: a cell write is on result while empty is low and leaves
//   on an edge with pop high. words that write no cell give no result.
//   cfg port: cfg_write with cfg_index 0 sets the column count, 1 the row
//   count; only while no word is in flight.
//   path: a word waits in the input queue, is parsed when the back end takes
//   it, and its result is registered in the result queue until popped.
//   throughput: one word per cycle, set by the parser update, while the result queue has room or is popped.
//   a stalled result side fills the two-entry result queue, then the
//   two-entry input queue, then full rises; nothing is dropped.
//   reset: cursor at 0,0, white on black, grid 80 by 25, both queues empty.
`timescale 1ns / 1ps
`default_nettype none

module text_cell_writer_color_escapes (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [twc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [twc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            push,
	input  twc_pkg::in_word_t               item,
	output logic                            full,
	input  logic                            pop,
	output twc_pkg::out_word_t              result,
	output logic                            empty
);

	twc_pkg::cls_t cls;
	logic          cls_empty;
	logic          cls_pop;

	twc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.pop    (cls_pop),
		.empty  (cls_empty),
		.cls    (cls)
	);

	twc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cls_empty (cls_empty),
		.cls       (cls),
		.cls_pop   (cls_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/twc_queue.sv -----
// short queue of classified words between front and back
// depends on twc_pkg
`timescale 1ns / 1ps
`default_nettype none

module twc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  twc_pkg::cls_t wr_word,
	input  logic          pop,
	output logic          empty,
	output twc_pkg::cls_t rd_word
);

	localparam logic [twc_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
		twc_pkg::QUEUE_PTR_W'(twc_pkg::QUEUE_DEPTH - 1);
	localparam logic [twc_pkg::QUEUE_PTR_W:0] DEPTH_CNT =
		(twc_pkg::QUEUE_PTR_W + 1)'(twc_pkg::QUEUE_DEPTH);

	twc_pkg::cls_t                     mem_q [twc_pkg::QUEUE_DEPTH];
	logic [twc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [twc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [twc_pkg::QUEUE_PTR_W:0]     count_q;
	logic                              do_push;
	logic                              do_pop;

	assign full    = (count_q == DEPTH_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/twc_front.sv -----
// front end: accepts input words, decodes escape characters and hex digits
// depends on twc_pkg and twc_queue
`timescale 1ns / 1ps
`default_nettype none

module twc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  twc_pkg::in_word_t item,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output twc_pkg::cls_t     cls
);

	twc_pkg::cls_t cls_in;
	logic [4:0]    hex;

	always_comb begin
		hex               = twc_pkg::hex_decode(item.char_code);
		cls_in.mode       = item.mode;
		cls_in.eos        = item.end_of_string;
		cls_in.tile_u     = {item.char_code[3:0], 4'd0};
		cls_in.tile_v     = {item.char_code[7:4], 4'd0};
		cls_in.is_percent = (item.char_code == twc_pkg::CHAR_PERCENT);
		cls_in.is_newline = (item.char_code == twc_pkg::CHAR_NEWLINE);
		cls_in.is_slash   = (item.char_code == twc_pkg::CHAR_SLASH);
		cls_in.is_hex     = hex[4];
		cls_in.hex_digit  = hex[3:0];
		cls_in.pos_x      = item.pos_x;
		cls_in.pos_y      = item.pos_y;
		cls_in.rgb        = {item.red, item.green, item.blue};
	end

	twc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.wr_word (cls_in),
		.pop     (pop),
		.empty   (empty),
		.rd_word (cls)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/twc_back.sv -----
// back end: escape parser, cursor and color state, result queue
// depends on twc_pkg
`timescale 1ns / 1ps
`default_nettype none

module twc_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [twc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [twc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               cls_empty,
	input  twc_pkg::cls_t                      cls,
	output logic                               cls_pop,
	output twc_pkg::out_word_t                 result,
	output logic                               empty,
	input  logic                               pop
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TEXT,
		PH_ESC,
		PH_FRUN,
		PH_SLASH,
		PH_BSTART,
		PH_BRUN,
		PH_STOP
	} phase_t;

	localparam logic [twc_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
		twc_pkg::QUEUE_PTR_W'(twc_pkg::QUEUE_DEPTH - 1);
	localparam logic [twc_pkg::QUEUE_PTR_W:0] DEPTH_CNT =
		(twc_pkg::QUEUE_PTR_W + 1)'(twc_pkg::QUEUE_DEPTH);

	logic [7:0]  cols_q;
	logic [6:0]  rows_q;
	logic [7:0]  col_q, col_n;
	logic [7:0]  row_q, row_n;
	logic [7:0]  line_q, line_n;
	phase_t      phase_q, phase_n;
	logic [23:0] hex_q, hex_n;
	logic [2:0]  hpos_q, hpos_n;
	logic        over_q, over_n;
	logic [23:0] fore_q, fore_n;
	logic [23:0] back_q, back_n;

	twc_pkg::out_word_t              oq_mem_q [twc_pkg::QUEUE_DEPTH];
	logic [twc_pkg::QUEUE_PTR_W-1:0] oq_wr_q;
	logic [twc_pkg::QUEUE_PTR_W-1:0] oq_rd_q;
	logic [twc_pkg::QUEUE_PTR_W:0]   oq_cnt_q;

	logic        oq_full;
	logic        oq_pop;
	logic        take;
	logic        emit;
	logic        do_plain;
	logic        in_grid;
	logic [7:0]  ucols;
	logic [6:0]  urows;
	logic [7:0]  col_inc;
	logic [7:0]  row_inc;
	logic [8:0]  col_step;
	twc_pkg::out_word_t out_word;

	assign oq_full = (oq_cnt_q == DEPTH_CNT);
	assign empty   = (oq_cnt_q == '0);
	assign oq_pop  = pop && !empty;
	assign take    = !cls_empty && (!oq_full || oq_pop);
	assign cls_pop = take;
	assign result  = oq_mem_q[oq_rd_q];

	assign ucols    = (cols_q > twc_pkg::MAX_COLUMNS) ? twc_pkg::MAX_COLUMNS : cols_q;
	assign urows    = (rows_q > twc_pkg::MAX_ROWS) ? twc_pkg::MAX_ROWS : rows_q;
	assign in_grid  = (col_q < ucols) && (row_q < {1'b0, urows});
	assign col_inc  = (col_q == 8'hFF) ? 8'hFF : col_q + 8'd1;
	assign row_inc  = (row_q == 8'hFF) ? 8'hFF : row_q + 8'd1;
	assign col_step = {1'b0, col_q} + 9'd1;

	always_comb begin
		out_word.cell_x     = col_q[6:0];
		out_word.cell_y     = row_q[5:0];
		out_word.tile_u     = cls.tile_u;
		out_word.tile_v     = cls.tile_v;
		out_word.fore_red   = fore_q[23:16];
		out_word.fore_green = fore_q[15:8];
		out_word.fore_blue  = fore_q[7:0];
		out_word.back_red   = back_q[23:16];
		out_word.back_green = back_q[15:8];
		out_word.back_blue  = back_q[7:0];
	end

	always_comb begin
		col_n    = col_q;
		row_n    = row_q;
		line_n   = line_q;
		phase_n  = phase_q;
		hex_n    = hex_q;
		hpos_n   = hpos_q;
		over_n   = over_q;
		fore_n   = fore_q;
		back_n   = back_q;
		emit     = 1'b0;
		do_plain = 1'b0;
		case (cls.mode)
			twc_pkg::MODE_STRING: begin
				unique case (phase_q)
					PH_IDLE: begin
						line_n   = col_q;
						do_plain = 1'b1;
					end
					PH_TEXT: begin
						do_plain = 1'b1;
					end
					PH_ESC: begin
						if (cls.is_percent) begin
							emit    = in_grid;
							col_n   = col_inc;
							phase_n = PH_TEXT;
						end else if (cls.is_newline) begin
							row_n   = row_inc;
							col_n   = line_q;
							phase_n = PH_TEXT;
						end else if (cls.is_hex) begin
							hex_n   = {20'd0, cls.hex_digit};
							hpos_n  = 3'd1;
							over_n  = 1'b0;
							phase_n = PH_FRUN;
						end else begin
							phase_n = PH_STOP;
						end
					end
					PH_FRUN, PH_BRUN: begin
						if (!over_q && cls.is_hex) begin
							hex_n = {hex_q[19:0], cls.hex_digit};
						end else begin
							over_n = 1'b1;
						end
						hpos_n = hpos_q + 3'd1;
						if (hpos_n >= 3'd6) begin
							if (phase_q == PH_FRUN) begin
								fore_n  = hex_n;
								phase_n = PH_SLASH;
							end else begin
								back_n  = hex_n;
								phase_n = PH_TEXT;
							end
						end
					end
					PH_SLASH: begin
						if (cls.is_slash) begin
							phase_n = PH_BSTART;
						end else begin
							do_plain = 1'b1;
						end
					end
					PH_BSTART: begin
						if (cls.is_hex) begin
							hex_n   = {20'd0, cls.hex_digit};
							hpos_n  = 3'd1;
							over_n  = 1'b0;
							phase_n = PH_BRUN;
						end else begin
							phase_n = PH_STOP;
						end
					end
					PH_STOP: begin
					end
				endcase
				if (do_plain) begin
					if (cls.is_percent) begin
						phase_n = PH_ESC;
					end else begin
						phase_n = PH_TEXT;
						emit    = in_grid;
						col_n   = col_inc;
					end
				end
				if (cls.eos) begin
					if (phase_n == PH_FRUN) begin
						fore_n = hex_n;
					end else if (phase_n == PH_BRUN) begin
						back_n = hex_n;
					end
					phase_n = PH_IDLE;
					hex_n   = '0;
					hpos_n  = '0;
					over_n  = 1'b0;
				end
			end
			twc_pkg::MODE_SINGLE: begin
				emit  = in_grid;
				col_n = (col_step > {1'b0, ucols}) ? ucols : col_step[7:0];
			end
			twc_pkg::MODE_MOVE: begin
				col_n = cls.pos_x;
				row_n = cls.pos_y;
			end
			twc_pkg::MODE_FORE: begin
				fore_n = cls.rgb;
			end
			twc_pkg::MODE_BACK: begin
				back_n = cls.rgb;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= twc_pkg::COLUMNS_RESET;
			rows_q   <= twc_pkg::ROWS_RESET;
			col_q    <= '0;
			row_q    <= '0;
			line_q   <= '0;
			phase_q  <= PH_IDLE;
			hex_q    <= '0;
			hpos_q   <= '0;
			over_q   <= 1'b0;
			fore_q   <= twc_pkg::FORE_RESET;
			back_q   <= twc_pkg::BACK_RESET;
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == twc_pkg::CFG_COLUMNS) begin
					cols_q <= cfg_data;
				end else if (cfg_index == twc_pkg::CFG_ROWS) begin
					rows_q <= cfg_data[6:0];
				end
			end
			if (take) begin
				col_q   <= col_n;
				row_q   <= row_n;
				line_q  <= line_n;
				phase_q <= phase_n;
				hex_q   <= hex_n;
				hpos_q  <= hpos_n;
				over_q  <= over_n;
				fore_q  <= fore_n;
				back_q  <= back_n;
			end
			if (take && emit) begin
				oq_wr_q <= (oq_wr_q == LAST_PTR) ? '0 : oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= (oq_rd_q == LAST_PTR) ? '0 : oq_rd_q + 1'b1;
			end
			if ((take && emit) && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (oq_pop && !(take && emit)) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			oq_mem_q[oq_wr_q] <= out_word;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/twc_checker.sv -----
// port-level checks of the text cell writer, bound to the top level
// depends on twc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module twc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  logic                            pop,
	input  twc_pkg::out_word_t              result,
	input  logic                            empty
);

	// glyph offsets are whole tiles
	`ASSERT_IMP(a_tile_aligned, clk, arst_n, !empty, (result.tile_u[3:0] == 4'd0) && (result.tile_v[3:0] == 4'd0))

	// a waiting word holds until popped
	`ASSERT_NXT(a_result_held, clk, arst_n, !empty && !pop, !empty && $stable(result))

	// the input queue only fills from a push
	`ASSERT_IMP(a_full_needs_push, clk, arst_n, $rose(full), $past(push))

endmodule

bind text_cell_writer_color_escapes twc_checker u_checker (.*);

`default_nettype wire

// ----- bench/cell_write_scoreboard.sv -----
// scoreboard class for the text cell writer bench: predicts the cell writes
// of each accepted word and checks the block's results against them
// depends on twc_pkg
`timescale 1ns / 1ps

package cell_write_check_pkg;
	import twc_pkg::*;

	typedef enum logic [2:0] {
		PARSE_IDLE,
		PARSE_TEXT,
		PARSE_ESC,
		PARSE_FORE_RUN,
		PARSE_SLASH,
		PARSE_BACK_START,
		PARSE_BACK_RUN,
		PARSE_STOP
	} parse_phase_t;

	class cell_write_scoreboard;
		out_word_t    pending_cells[$];
		int unsigned  errors;
		logic [7:0]   columns;
		logic [6:0]   rows;
		logic [7:0]   col;
		logic [7:0]   row;
		logic [7:0]   line_start;
		parse_phase_t phase;
		logic [23:0]  hex_acc;
		logic [2:0]   hex_pos;
		logic         run_over;
		logic [23:0]  fore;
		logic [23:0]  back;

		function new();
			errors = 0;
			columns = COLUMNS_RESET;
			rows = ROWS_RESET;
			col = '0;
			row = '0;
			line_start = '0;
			clear_run();
			fore = FORE_RESET;
			back = BACK_RESET;
		endfunction

		function void clear_run();
			phase = PARSE_IDLE;
			hex_acc = '0;
			hex_pos = '0;
			run_over = 1'b0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [7:0] value);
			case (idx)
				CFG_COLUMNS: columns = value;
				CFG_ROWS: rows = value[6:0];
				default: ;
			endcase
		endfunction

		function int usable_columns();
			return (columns < MAX_COLUMNS) ? int'(columns) : int'(MAX_COLUMNS);
		endfunction

		function int usable_rows();
			return (rows < MAX_ROWS) ? int'(rows) : int'(MAX_ROWS);
		endfunction

		function int hex_of(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c) - int'("0");
			if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
			if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
			return -1;
		endfunction

		function logic [7:0] bump(logic [7:0] v);
			return (v == 8'hFF) ? v : v + 8'd1;
		endfunction

		function void write_cell(logic [7:0] c);
			out_word_t entry;
			if (int'(col) < usable_columns() && int'(row) < usable_rows()) begin
				entry.cell_x = col[6:0];
				entry.cell_y = row[5:0];
				entry.tile_u = {c[3:0], 4'h0};
				entry.tile_v = {c[7:4], 4'h0};
				{entry.fore_red, entry.fore_green, entry.fore_blue} = fore;
				{entry.back_red, entry.back_green, entry.back_blue} = back;
				pending_cells.push_back(entry);
			end
		endfunction

		function void print_char(logic [7:0] c);
			write_cell(c);
			col = bump(col);
		endfunction

		function void plain_text(logic [7:0] c);
			if (c == CHAR_PERCENT) begin
				phase = PARSE_ESC;
			end else begin
				phase = PARSE_TEXT;
				print_char(c);
			end
		endfunction

		function void start_run(int digit, parse_phase_t next);
			hex_acc = 24'(digit);
			hex_pos = 3'd1;
			run_over = 1'b0;
			phase = next;
		endfunction

		function void commit_color();
			if (phase == PARSE_FORE_RUN) fore = hex_acc;
			else back = hex_acc;
		endfunction

		function void string_char(logic [7:0] c, logic eos);
			int digit;
			digit = hex_of(c);
			case (phase)
				PARSE_IDLE: begin
					line_start = col;
					plain_text(c);
				end
				PARSE_TEXT: plain_text(c);
				PARSE_ESC: begin
					if (c == CHAR_PERCENT) begin
						print_char(c);
						phase = PARSE_TEXT;
					end else if (c == CHAR_NEWLINE) begin
						row = bump(row);
						col = line_start;
						phase = PARSE_TEXT;
					end else if (digit >= 0) begin
						start_run(digit, PARSE_FORE_RUN);
					end else begin
						phase = PARSE_STOP;
					end
				end
				PARSE_FORE_RUN, PARSE_BACK_RUN: begin
					if (!run_over && digit >= 0) hex_acc = {hex_acc[19:0], 4'(digit)};
					else run_over = 1'b1;
					hex_pos = hex_pos + 3'd1;
					if (hex_pos >= 3'd6) begin
						commit_color();
						phase = (phase == PARSE_FORE_RUN) ? PARSE_SLASH : PARSE_TEXT;
					end
				end
				PARSE_SLASH: begin
					if (c == CHAR_SLASH) phase = PARSE_BACK_START;
					else plain_text(c);
				end
				PARSE_BACK_START: begin
					if (digit >= 0) start_run(digit, PARSE_BACK_RUN);
					else phase = PARSE_STOP;
				end
				default: ;
			endcase
			if (eos) begin
				if (phase == PARSE_FORE_RUN || phase == PARSE_BACK_RUN) commit_color();
				clear_run();
			end
		endfunction

		function void note_word(in_word_t w);
			case (w.mode)
				MODE_STRING: string_char(w.char_code, w.end_of_string);
				MODE_SINGLE: begin
					write_cell(w.char_code);
					if (int'(col) + 1 > usable_columns()) col = 8'(usable_columns());
					else col = col + 8'd1;
				end
				MODE_MOVE: begin
					col = w.pos_x;
					row = w.pos_y;
				end
				MODE_FORE: fore = {w.red, w.green, w.blue};
				MODE_BACK: back = {w.red, w.green, w.blue};
				default: ;
			endcase
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s expected %0d got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_cell(out_word_t got);
			out_word_t want;
			if (pending_cells.size() == 0) begin
				$error("cell write with none expected: x %0d y %0d", got.cell_x, got.cell_y);
				errors++;
				return;
			end
			want = pending_cells.pop_front();
			compare_field("cell_x", want.cell_x, got.cell_x);
			compare_field("cell_y", want.cell_y, got.cell_y);
			compare_field("tile_u", want.tile_u, got.tile_u);
			compare_field("tile_v", want.tile_v, got.tile_v);
			compare_field("fore_red", want.fore_red, got.fore_red);
			compare_field("fore_green", want.fore_green, got.fore_green);
			compare_field("fore_blue", want.fore_blue, got.fore_blue);
			compare_field("back_red", want.back_red, got.back_red);
			compare_field("back_green", want.back_green, got.back_green);
			compare_field("back_blue", want.back_blue, got.back_blue);
		endfunction
	endclass

endpackage

// ----- bench/text_cell_writer_color_escapes_test.sv -----
// top of the text cell writer bench: drives directed and random words and
// grid sizes with random stalls on both sides, checks every cell write
// depends on twc_pkg, cell_write_check_pkg, text_cell_writer_color_escapes
`timescale 1ns / 1ps

module text_cell_writer_color_escapes_test;
	import twc_pkg::*;
	import cell_write_check_pkg::*;

	typedef logic [7:0] char_q_t[$];

	localparam int          CYCLE_LIMIT       = 400000;
	localparam int          SETTLE_CYCLES     = 8;
	localparam int          WORDS_PER_PHASE   = 250;
	localparam logic [2:0]  MODE_FIRST_UNUSED = 3'd5;
	localparam logic [2:0]  MODE_LAST_UNUSED  = 3'd7;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   push = 1'b0;
	in_word_t               item = '0;
	logic                   full;
	logic                   pop = 1'b0;
	out_word_t              result;
	logic                   empty;

	cell_write_scoreboard sb;
	int send_idle = 0;
	int recv_idle = 0;
	int words_sent = 0;
	int cycles = 0;

	text_cell_writer_color_escapes dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.item(item),
		.full(full),
		.pop(pop),
		.result(result),
		.empty(empty)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) sb.check_cell(result);
	end

	function automatic in_word_t random_word();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(in_word_t)-1:0];
	endfunction

	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		sb.note_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (sb.pending_cells.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [7:0] value);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		sb.set_register(idx, value);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_mode(input mode_t mode, input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		in_word_t w;
		w = random_word();
		w.mode = mode;
		w.char_code = a;
		{w.pos_x, w.pos_y} = {a, b};
		{w.red, w.green, w.blue} = {a, b, c};
		send_word(w);
	endtask

	function automatic in_word_t other_mode_word();
		in_word_t w;
		w = random_word();
		if ($urandom_range(99) < 90)
			w.mode = 3'($urandom_range(int'(MODE_SINGLE), int'(MODE_BACK)));
		else
			w.mode = 3'($urandom_range(int'(MODE_FIRST_UNUSED), int'(MODE_LAST_UNUSED)));
		return w;
	endfunction

	task automatic send_text(input char_q_t chars, input int interject_pct);
		in_word_t w;
		foreach (chars[i]) begin
			if ($urandom_range(99) < interject_pct) send_word(other_mode_word());
			w = random_word();
			w.mode = MODE_STRING;
			w.char_code = chars[i];
			w.end_of_string = (i == chars.size() - 1);
			send_word(w);
		end
	endtask

	task automatic send_literal(input string s);
		char_q_t chars;
		for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
		send_text(chars, 0);
	endtask

	function automatic logic [7:0] pick_hex();
		string digits;
		digits = "0123456789ABCDEFabcdef";
		return digits[$urandom_range(21)];
	endfunction

	function automatic logic [7:0] pick_non_hex();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (sb.hex_of(c) >= 0 || c == CHAR_PERCENT || c == CHAR_NEWLINE);
		return c;
	endfunction

	function automatic void add_run(ref char_q_t chars, input logic [7:0] lead);
		chars.push_back(lead);
		for (int i = 0; i < 6; i++) begin
			if ($urandom_range(99) < 6) chars.push_back(pick_non_hex());
			else chars.push_back(pick_hex());
		end
	endfunction

	task automatic send_random_string();
		char_q_t chars;
		in_word_t w;
		int r;
		logic [7:0] c;
		if ($urandom_range(99) < 35) begin
			w = random_word();
			w.mode = MODE_MOVE;
			r = $urandom_range(99);
			if (r < 75) begin
				w.pos_x = 8'($urandom_range(0, sb.usable_columns()));
				w.pos_y = 8'($urandom_range(0, sb.usable_rows()));
			end else if (r < 85) begin
				w.pos_x = 8'($urandom_range(250, 255));
				w.pos_y = 8'($urandom_range(250, 255));
			end
			send_word(w);
		end
		repeat ($urandom_range(1, 5)) begin
			r = $urandom_range(99);
			if (r < 40) begin
				do c = 8'($urandom_range(255)); while (c == CHAR_PERCENT);
				chars.push_back(c);
			end else if (r < 50) begin
				chars.push_back(CHAR_PERCENT);
				chars.push_back(CHAR_PERCENT);
			end else if (r < 58) begin
				chars.push_back(CHAR_PERCENT);
				chars.push_back(CHAR_NEWLINE);
			end else if (r < 80) begin
				add_run(chars, CHAR_PERCENT);
				if ($urandom_range(99) < 70) add_run(chars, CHAR_SLASH);
			end else if (r < 86) begin
				chars.push_back(CHAR_PERCENT);
				chars.push_back(pick_non_hex());
			end else if (r < 91) begin
				chars.push_back(CHAR_SLASH);
			end else begin
				chars.push_back(8'($urandom_range(255)));
			end
		end
		if ($urandom_range(99) < 15) chars = chars[0:$urandom_range(0, chars.size() - 1)];
		send_text(chars, 6);
	endtask

	task automatic run_directed();
		send_mode(MODE_SINGLE, 8'h00, 8'h00, 8'h00);
		send_mode(MODE_SINGLE, 8'hFF, 8'hFF, 8'hFF);
		send_mode(MODE_MOVE, 8'hFF, 8'hFF, 8'h00);
		send_mode(MODE_SINGLE, "A", 8'h00, 8'h00);
		send_mode(MODE_MOVE, 8'd2, 8'd1, 8'h00);
		send_mode(MODE_FORE, 8'h12, 8'h34, 8'h56);
		send_mode(MODE_BACK, 8'hFF, 8'h00, 8'hFF);
		send_literal("%%");
		send_literal("a%nb");
		send_literal("%9aF/3");
		send_literal("%q");
		send_literal("%");
		send_word(other_mode_word());
	endtask

	initial begin
		int cols_cfg [6];
		int rows_cfg [6];
		int target;
		cols_cfg = '{128, 1, 40, 128, 7, 80};
		rows_cfg = '{64, 1, 12, 3, 64, 25};
		sb = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 38;
		recv_idle = 81;
		run_directed();

		for (int p = 0; p < 6; p++) begin
			if (p < 2) begin
				send_idle = 38;
				recv_idle = 81;
			end else if (p < 4) begin
				send_idle = 81;
				recv_idle = 38;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_register(CFG_COLUMNS, 8'(cols_cfg[p]));
			write_register(CFG_ROWS, 8'(rows_cfg[p]));
			target = words_sent + WORDS_PER_PHASE;
			while (words_sent < target) begin
				if ($urandom_range(99) < 3) send_word(random_word());
				else send_random_string();
				if ($urandom_range(199) == 0) wait_idle();
			end
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending_cells.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- text_cell_writer_color_escapes.f -----
+incdir+hw/rtl
hw/rtl/twc_pkg.sv
hw/rtl/twc_queue.sv
hw/rtl/twc_front.sv
hw/rtl/twc_back.sv
hw/rtl/text_cell_writer_color_escapes.sv
hw/rtl/twc_checker.sv
bench/cell_write_scoreboard.sv
bench/text_cell_writer_color_escapes_test.sv
